/* rtl/core/bfbp_pkg.sv */
// ----------------------------------------------------------------------------
// bfbp_pkg
// Shared constants, types and helpers of the best-fit buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbp_pkg;

  localparam int unsigned MAX_BUFFERS   = 16;
  localparam int unsigned CAPACITY_BITS = 24;

  localparam int unsigned ID_W        = 4;
  localparam int unsigned CH_W        = 6;
  localparam int unsigned NS_W        = 19;
  localparam int unsigned CAP_FIELD_W = 24;
  localparam int unsigned STATUS_W    = 2;

  localparam int unsigned ID_SPACE = (MAX_BUFFERS < (2 ** ID_W)) ? MAX_BUFFERS : (2 ** ID_W);
  localparam int unsigned IDX_W    = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned ISS_W    = $clog2(ID_SPACE + 1);
  localparam int unsigned PROD_W   = CH_W + NS_W;
  localparam int unsigned CAP_W    = CAPACITY_BITS;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CAP_W-1:0] cap_t;

  localparam cap_t CAP_MAX = '1;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_INVALID   = 2'd2
  } status_e;

  // One free-list slot.
  typedef struct packed {
    logic valid;
    id_t  id;
    cap_t cap;
  } entry_t;

  // Running best-fit search result, walks the cell row.
  typedef struct packed {
    logic valid;
    logic have_any;
    logic have_fit;
    cap_t best;
    idx_t pick;
    id_t  pick_id;
  } token_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic append;
    logic remove;
    idx_t pos;
    id_t  id;
    cap_t cap;
    cap_t need;
  } cell_ctrl_t;

  function automatic idx_t id_to_idx(input id_t id);
    logic [ID_W+IDX_W-1:0] ext;
    ext = {{IDX_W{1'b0}}, id};
    return ext[IDX_W-1:0];
  endfunction

  function automatic logic [CAP_FIELD_W-1:0] cap_field(input cap_t c);
    logic [CAP_W+CAP_FIELD_W-1:0] ext;
    ext = {{CAP_FIELD_W{1'b0}}, c};
    return ext[CAP_FIELD_W-1:0];
  endfunction

  function automatic cap_t saturate_need(input logic [PROD_W-1:0] p);
    logic [PROD_W+CAP_W-1:0] pw;
    logic [PROD_W+CAP_W-1:0] cm;
    pw = {{CAP_W{1'b0}}, p};
    cm = {{PROD_W{1'b0}}, CAP_MAX};
    if (pw > cm) begin
      return CAP_MAX;
    end
    return pw[CAP_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/bfbp_req_if.sv */
// ----------------------------------------------------------------------------
// bfbp_req_if
// Request channel of the buffer pool: acquire or release transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfbp_req_if import bfbp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            operation;
  logic [CH_W-1:0] num_channels;
  logic [NS_W-1:0] num_samples;
  logic [ID_W-1:0] buffer_id;

  modport source (output valid, operation, num_channels, num_samples, buffer_id,
                  input ready);
  modport sink   (input valid, operation, num_channels, num_samples, buffer_id,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/bfbp_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfbp_rsp_if
// Response channel of the buffer pool: one transaction per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfbp_rsp_if import bfbp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ID_W-1:0]        granted_id;
  logic [CAP_FIELD_W-1:0] capacity;
  logic                   was_new;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, granted_id, capacity, was_new, status, input ready);
  modport sink   (input valid, granted_id, capacity, was_new, status, output ready);
endinterface

`default_nettype wire

/* rtl/core/best_fit_buffer_pool_core.sv */
// ----------------------------------------------------------------------------
// best_fit_buffer_pool_core
// Best-fit allocator for a pool of reusable sample buffers named by IDs.
//
// req_i carries acquire (channels x samples) and release (buffer ID)
// transactions; rsp_o returns exactly one transaction per request with the
// granted ID, its capacity, a fresh-ID flag and a status code.
// Free IDs sit in a row of MAX_BUFFERS cells in release order. An acquire
// with a non-empty free list sends a search token down the row, one cell
// per cycle; the matching slot is removed as the token leaves the last cell.
// An acquire with an empty free list issues a fresh ID or reports exhausted.
// A valid release reads the capacity RAM; a rejected one skips that read.
// One request is in flight at a time; the next is taken the cycle after the
// result enters the output register.
// A result waits in the output register while rsp_o.ready is low; a
// further finished result holds the sequencer until the register drains.
// Reset empties the free list and forgets all issued IDs; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module best_fit_buffer_pool_core import bfbp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bfbp_req_if.sink  req_i,
  bfbp_rsp_if.source rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DISPATCH,
    S_SCAN,
    S_REL_CHK,
    S_REL_APP,
    S_RESULT
  } state_e;

  state_e                state_q;
  logic                  op_q;
  logic [CH_W-1:0]       ch_q;
  logic [NS_W-1:0]       ns_q;
  id_t                   id_q;
  logic [PROD_W-1:0]     prod_q;
  cap_t                  need_q;
  logic                  start_q;
  logic [CNT_W-1:0]      count_q;
  logic [ISS_W-1:0]      issued_q;
  logic [MAX_BUFFERS-1:0] in_pool_q;

  id_t                   res_id_q;
  logic [CAP_FIELD_W-1:0] res_cap_q;
  logic                  res_new_q;
  status_e               res_st_q;

  logic                  out_valid_q;
  id_t                   out_id_q;
  logic [CAP_FIELD_W-1:0] out_cap_q;
  logic                  out_new_q;
  status_e               out_st_q;

  entry_t     ent_w [MAX_BUFFERS+1];
  token_t     tok_w [MAX_BUFFERS+1];
  cell_ctrl_t ctrl;
  token_t     fin;
  cap_t       sat_need;
  cap_t       new_cap;
  logic       rel_bad;
  logic [ID_W:0] id_ext;
  logic [ID_W:0] iss_ext;

  logic       ram_we;
  idx_t       ram_waddr;
  cap_t       ram_wdata;
  logic       ram_re;
  cap_t       ram_rdata;

  assign fin      = tok_w[MAX_BUFFERS];
  assign sat_need = saturate_need(prod_q);
  assign new_cap  = (fin.best < need_q) ? need_q : fin.best;
  assign id_ext   = {1'b0, id_q};
  assign iss_ext  = (ID_W + 1)'(issued_q);
  assign rel_bad  = (id_ext >= iss_ext) || in_pool_q[id_to_idx(id_q)] ||
                    (count_q >= CNT_W'(MAX_BUFFERS));

  assign ent_w[MAX_BUFFERS] = '0;
  assign tok_w[0] = '{valid: start_q, default: '0};

  for (genvar g = 0; g < MAX_BUFFERS; g++) begin : g_cell
    bfbp_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(g)),
      .ctrl_i (ctrl),
      .next_i (ent_w[g+1]),
      .ent_o  (ent_w[g]),
      .tok_i  (tok_w[g]),
      .tok_o  (tok_w[g+1])
    );
  end

  always_comb begin
    ctrl      = '0;
    ctrl.need = need_q;
    if ((state_q == S_SCAN) && fin.valid) begin
      ctrl.remove = 1'b1;
      ctrl.pos    = fin.pick;
    end else if (state_q == S_REL_APP) begin
      ctrl.append = 1'b1;
      ctrl.pos    = count_q[IDX_W-1:0];
      ctrl.id     = id_q;
      ctrl.cap    = ram_rdata;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = IDX_W'(issued_q);
    ram_wdata = sat_need;
    if ((state_q == S_DISPATCH) && (op_q == OP_ACQUIRE) && (count_q == '0) &&
        (issued_q < ISS_W'(ID_SPACE))) begin
      ram_we = 1'b1;
    end else if ((state_q == S_SCAN) && fin.valid) begin
      ram_we    = fin.best < need_q;
      ram_waddr = id_to_idx(fin.pick_id);
      ram_wdata = need_q;
    end
  end

  assign ram_re = (state_q == S_REL_CHK) && !rel_bad;

  bfbp_ram #(
    .Width (CAP_W),
    .Depth (MAX_BUFFERS)
  ) u_cap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (id_to_idx(id_q)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ACQUIRE;
      ch_q        <= '0;
      ns_q        <= '0;
      id_q        <= '0;
      prod_q      <= '0;
      need_q      <= '0;
      start_q     <= 1'b0;
      count_q     <= '0;
      issued_q    <= '0;
      in_pool_q   <= '0;
      res_id_q    <= '0;
      res_cap_q   <= '0;
      res_new_q   <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_id_q    <= '0;
      out_cap_q   <= '0;
      out_new_q   <= 1'b0;
      out_st_q    <= ST_OK;
    end else begin
      if (out_valid_q && rsp_o.ready && (state_q != S_RESULT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            op_q    <= req_i.operation;
            ch_q    <= req_i.num_channels;
            ns_q    <= req_i.num_samples;
            id_q    <= req_i.buffer_id;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= PROD_W'(ch_q) * PROD_W'(ns_q);
          state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          need_q <= sat_need;
          if (op_q == OP_RELEASE) begin
            state_q <= S_REL_CHK;
          end else if (count_q != '0) begin
            start_q <= 1'b1;
            state_q <= S_SCAN;
          end else if (issued_q >= ISS_W'(ID_SPACE)) begin
            res_id_q  <= '0;
            res_cap_q <= '0;
            res_new_q <= 1'b0;
            res_st_q  <= ST_EXHAUSTED;
            state_q   <= S_RESULT;
          end else begin
            res_id_q  <= ID_W'(issued_q);
            res_cap_q <= cap_field(sat_need);
            res_new_q <= 1'b1;
            res_st_q  <= ST_OK;
            issued_q  <= issued_q + 1'b1;
            state_q   <= S_RESULT;
          end
        end
        S_SCAN: begin
          start_q <= 1'b0;
          if (fin.valid) begin
            count_q   <= count_q - 1'b1;
            in_pool_q[id_to_idx(fin.pick_id)] <= 1'b0;
            res_id_q  <= fin.pick_id;
            res_cap_q <= cap_field(new_cap);
            res_new_q <= 1'b0;
            res_st_q  <= ST_OK;
            state_q   <= S_RESULT;
          end
        end
        S_REL_CHK: begin
          if (rel_bad) begin
            res_id_q  <= id_q;
            res_cap_q <= '0;
            res_new_q <= 1'b0;
            res_st_q  <= ST_INVALID;
            state_q   <= S_RESULT;
          end else begin
            state_q <= S_REL_APP;
          end
        end
        S_REL_APP: begin
          count_q   <= count_q + 1'b1;
          in_pool_q[id_to_idx(id_q)] <= 1'b1;
          res_id_q  <= id_q;
          res_cap_q <= cap_field(ram_rdata);
          res_new_q <= 1'b0;
          res_st_q  <= ST_OK;
          state_q   <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q <= 1'b1;
            out_id_q    <= res_id_q;
            out_cap_q   <= res_cap_q;
            out_new_q   <= res_new_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.granted_id = out_id_q;
  assign rsp_o.capacity   = out_cap_q;
  assign rsp_o.was_new    = out_new_q;
  assign rsp_o.status     = out_st_q;

endmodule

`default_nettype wire

/* rtl/core/bfbp_ram.sv */
// ----------------------------------------------------------------------------
// bfbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bfbp_cell.sv */
// ----------------------------------------------------------------------------
// bfbp_cell
// One free-list slot plus one stage of the best-fit search token.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbp_cell import bfbp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire idx_t       idx_i,
  input  wire cell_ctrl_t ctrl_i,
  input  wire entry_t     next_i,
  output entry_t          ent_o,
  input  wire token_t     tok_i,
  output token_t          tok_o
);

  entry_t ent_q, ent_d;
  token_t tok_q, tok_d;

  always_comb begin
    ent_d = ent_q;
    if (ctrl_i.remove && (idx_i >= ctrl_i.pos)) begin
      ent_d = next_i;
    end else if (ctrl_i.append && (idx_i == ctrl_i.pos)) begin
      ent_d = '{valid: 1'b1, id: ctrl_i.id, cap: ctrl_i.cap};
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && ent_q.valid) begin
      if (ent_q.cap >= ctrl_i.need) begin
        if (!tok_i.have_fit || (ent_q.cap < tok_i.best)) begin
          tok_d.have_any = 1'b1;
          tok_d.have_fit = 1'b1;
          tok_d.best     = ent_q.cap;
          tok_d.pick     = idx_i;
          tok_d.pick_id  = ent_q.id;
        end
      end else if (!tok_i.have_fit) begin
        if (!tok_i.have_any || (ent_q.cap > tok_i.best)) begin
          tok_d.have_any = 1'b1;
          tok_d.best     = ent_q.cap;
          tok_d.pick     = idx_i;
          tok_d.pick_id  = ent_q.id;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
      tok_q <= '0;
    end else begin
      ent_q <= ent_d;
      tok_q <= tok_d;
    end
  end

  assign ent_o = ent_q;
  assign tok_o = tok_q;

endmodule

`default_nettype wire
